[sv/amd_pkg.sv]
// Package for the accelerometer motion detector: constants, codes and pipeline types.
package amd_pkg;

   localparam int WINDOW     = 8;
   localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W     = $clog2(WINDOW + 1);
   localparam int AXIS_W     = 16;
   localparam int SUM_W      = AXIS_W + $clog2(WINDOW);
   localparam int DIFF_W     = SUM_W + 1;
   localparam int DSQ_W      = 2 * DIFF_W;
   localparam int DEV_W      = DSQ_W + 2;
   localparam int CSQ_W      = 2 * SUM_W;
   localparam int MAG_W      = CSQ_W + 2;
   localparam int MAG_LO_W   = MAG_W / 2;
   localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
   localparam int CFG_W      = 16;
   localparam int T2_W       = 2 * CFG_W;
   localparam int PLO_W      = T2_W + MAG_LO_W;
   localparam int PHI_W      = T2_W + MAG_HI_W;
   localparam int PROD_W     = T2_W + MAG_W;
   localparam int CMP_W      = DEV_W + T2_W;
   localparam int ENTRY_W    = 3 * AXIS_W;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [CFG_W-1:0] DISCARD_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd655;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic REG_DISCARD   = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   typedef struct packed {
      logic eval;
      logic ovf;
      logic cal;
      logic disc;
   } ctrl_type;

   function automatic logic signed [SUM_W-1:0] sum_update(
      input logic signed [SUM_W-1:0]  sum,
      input logic signed [AXIS_W-1:0] old_val,
      input logic signed [AXIS_W-1:0] new_val,
      input logic                     sub
   );
      logic signed [SUM_W:0] acc;
      acc = (SUM_W+1)'(sum) + (SUM_W+1)'(new_val);
      if (sub) begin
         acc = acc - (SUM_W+1)'(old_val);
      end
      return acc[SUM_W-1:0];
   endfunction

endpackage

[sv/accel_motion_detector_unit.sv]
// Accelerometer motion detector: discard timer, ring store, window sums, trigger pipeline.
//
// Usage: each request on req_ is either a millisecond tick (command = tick) or an
// accelerometer sample. Every request produces exactly one response on rsp_, in order.
// Samples arriving before discard_ms ticks have passed are flagged sample_discarded.
// The first WINDOW kept samples calibrate the reference sum; afterwards each kept
// sample updates the running window sum and rsp_motion_trigger reports whether the
// deviation from the reference exceeds threshold_frac of its magnitude, or overflow.
// Throughput is one request per cycle while the output is not stalled by rsp_ready,
// set by the single read-modify-write of the ring store and window sums per request.
// For a kept sample the ring store is read and written at the same slot on the accepting edge.
// With a response waiting and rsp_ready low the whole pipeline holds and req_ready drops
// until the output register can move. Reset (synchronous, active high) clears timer,
// slot, fill count, calibration and sums and loads discard_ms = 1000 and threshold_frac = 655.
// Registers sit on the APB-style port at byte 0 (discard_ms) and byte 4
// (threshold_frac); write only while no requests are in flight.
module accel_motion_detector_unit
   import amd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic signed [AXIS_W-1:0] req_accel_x,
   input  logic signed [AXIS_W-1:0] req_accel_y,
   input  logic signed [AXIS_W-1:0] req_accel_z,
   input  logic                     req_data_overflow,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_motion_trigger,
   output logic                     rsp_is_calibrated,
   output logic                     rsp_sample_discarded,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   logic [CFG_W-1:0] discard_ff, threshold_ff;
   logic [CFG_W-1:0] elapsed_ff, elapsed_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic cal_ff, cal_in;
   logic signed [SUM_W-1:0] wsum_x_ff, wsum_y_ff, wsum_z_ff;
   logic signed [SUM_W-1:0] wsum_x_in, wsum_y_in, wsum_z_in;
   logic signed [SUM_W-1:0] csum_x_ff, csum_y_ff, csum_z_ff;

   logic [ENTRY_W-1:0] store_mem [WINDOW];
   logic [ENTRY_W-1:0] rd_ff;

   logic adv, accept, kept, cfg_wr;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   ctrl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   ctrl_type c1_in;
   logic sub1_ff, cap1_ff, keep1_ff;
   logic signed [AXIS_W-1:0] x1_ff, y1_ff, z1_ff;

   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic [DSQ_W-1:0] dsqx3_ff, dsqy3_ff, dsqz3_ff;
   logic [CSQ_W-1:0] csqx3_ff, csqy3_ff, csqz3_ff;
   logic [T2_W-1:0]  t2_3_ff, t2_4_ff;
   logic signed [DSQ_W-1:0] dsqx_in, dsqy_in, dsqz_in;
   logic signed [CSQ_W-1:0] csqx_in, csqy_in, csqz_in;
   logic [DEV_W-1:0] dev4_ff, dev5_ff, dev6_ff;
   logic [MAG_W-1:0] mag4_ff;
   logic [PLO_W-1:0] plo5_ff;
   logic [PHI_W-1:0] phi5_ff;
   logic [PROD_W-1:0] prod6_ff;
   logic trig7_ff, cal7_ff, disc7_ff;
   logic [CMP_W-1:0] lhs6, rhs6;

   assign adv       = !v7_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign kept      = (req_command == CMD_SAMPLE) && (elapsed_ff >= discard_ff);

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff   <= DISCARD_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_DISCARD:   discard_ff   <= pwdata[CFG_W-1:0];
            REG_THRESHOLD: threshold_ff <= pwdata[CFG_W-1:0];
            default:       discard_ff   <= discard_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DISCARD:   prdata = DATA_W'(discard_ff);
         REG_THRESHOLD: prdata = DATA_W'(threshold_ff);
         default:       prdata = '0;
      endcase
   end

   // request control state
   always_comb begin
      elapsed_in = elapsed_ff;
      slot_in    = slot_ff;
      fill_in    = fill_ff;
      cal_in     = cal_ff;
      if (req_command == CMD_TICK) begin
         if (elapsed_ff < discard_ff) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else if (kept) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (!cal_ff) begin
            fill_in = fill_ff + 1'b1;
            if (fill_in >= FILL_W'(WINDOW)) begin
               cal_in = 1'b1;
            end
         end
      end
      c1_in.eval = kept && cal_ff;
      c1_in.ovf  = req_data_overflow;
      c1_in.cal  = cal_in;
      c1_in.disc = (req_command == CMD_SAMPLE) && !kept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         slot_ff    <= '0;
         fill_ff    <= '0;
         cal_ff     <= 1'b0;
      end else if (accept) begin
         elapsed_ff <= elapsed_in;
         slot_ff    <= slot_in;
         fill_ff    <= fill_in;
         cal_ff     <= cal_in;
      end
   end

   // ring store: read old entry and write new one at the same slot
   always_ff @(posedge clock) begin
      if (accept && kept) begin
         rd_ff              <= store_mem[slot_ff];
         store_mem[slot_ff] <= {req_accel_x, req_accel_y, req_accel_z};
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff    <= c1_in;
         keep1_ff <= accept && kept;
         sub1_ff  <= cal_ff;
         cap1_ff  <= !cal_ff && cal_in;
         x1_ff    <= req_accel_x;
         y1_ff    <= req_accel_y;
         z1_ff    <= req_accel_z;
      end
   end

   // stage 1: window sum update
   assign wsum_x_in = sum_update(wsum_x_ff, rd_ff[3*AXIS_W-1:2*AXIS_W], x1_ff, sub1_ff);
   assign wsum_y_in = sum_update(wsum_y_ff, rd_ff[2*AXIS_W-1:AXIS_W], y1_ff, sub1_ff);
   assign wsum_z_in = sum_update(wsum_z_ff, rd_ff[AXIS_W-1:0], z1_ff, sub1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_x_ff <= '0;
         wsum_y_ff <= '0;
         wsum_z_ff <= '0;
         csum_x_ff <= '0;
         csum_y_ff <= '0;
         csum_z_ff <= '0;
      end else if (adv && v1_ff && keep1_ff) begin
         wsum_x_ff <= wsum_x_in;
         wsum_y_ff <= wsum_y_in;
         wsum_z_ff <= wsum_z_in;
         if (cap1_ff) begin
            csum_x_ff <= wsum_x_in;
            csum_y_ff <= wsum_y_in;
            csum_z_ff <= wsum_z_in;
         end
      end
   end

   // stage 2: deviation from reference
   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff  <= c1_ff;
         dx2_ff <= DIFF_W'(wsum_x_in) - DIFF_W'(csum_x_ff);
         dy2_ff <= DIFF_W'(wsum_y_in) - DIFF_W'(csum_y_ff);
         dz2_ff <= DIFF_W'(wsum_z_in) - DIFF_W'(csum_z_ff);
      end
   end

   // stage 3: squares
   assign dsqx_in = dx2_ff * dx2_ff;
   assign dsqy_in = dy2_ff * dy2_ff;
   assign dsqz_in = dz2_ff * dz2_ff;
   assign csqx_in = csum_x_ff * csum_x_ff;
   assign csqy_in = csum_y_ff * csum_y_ff;
   assign csqz_in = csum_z_ff * csum_z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c3_ff    <= c2_ff;
         dsqx3_ff <= dsqx_in;
         dsqy3_ff <= dsqy_in;
         dsqz3_ff <= dsqz_in;
         csqx3_ff <= csqx_in;
         csqy3_ff <= csqy_in;
         csqz3_ff <= csqz_in;
         t2_3_ff  <= T2_W'(threshold_ff) * T2_W'(threshold_ff);
      end
   end

   // stage 4: magnitude sums
   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff   <= c3_ff;
         dev4_ff <= DEV_W'(dsqx3_ff) + DEV_W'(dsqy3_ff) + DEV_W'(dsqz3_ff);
         mag4_ff <= MAG_W'(csqx3_ff) + MAG_W'(csqy3_ff) + MAG_W'(csqz3_ff);
         t2_4_ff <= t2_3_ff;
      end
   end

   // stage 5: threshold times magnitude, split in halves
   always_ff @(posedge clock) begin
      if (adv) begin
         c5_ff   <= c4_ff;
         dev5_ff <= dev4_ff;
         plo5_ff <= PLO_W'(t2_4_ff) * PLO_W'(mag4_ff[MAG_LO_W-1:0]);
         phi5_ff <= PHI_W'(t2_4_ff) * PHI_W'(mag4_ff[MAG_W-1:MAG_LO_W]);
      end
   end

   // stage 6: combine partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         c6_ff    <= c5_ff;
         dev6_ff  <= dev5_ff;
         prod6_ff <= PROD_W'(plo5_ff) + (PROD_W'(phi5_ff) << MAG_LO_W);
      end
   end

   // stage 7: compare into output register
   assign lhs6 = {dev6_ff, {T2_W{1'b0}}};
   assign rhs6 = CMP_W'(prod6_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         trig7_ff <= c6_ff.eval && ((lhs6 > rhs6) || c6_ff.ovf);
         cal7_ff  <= c6_ff.cal;
         disc7_ff <= c6_ff.disc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   assign rsp_valid            = v7_ff;
   assign rsp_motion_trigger   = trig7_ff;
   assign rsp_is_calibrated    = cal7_ff;
   assign rsp_sample_discarded = disc7_ff;

endmodule
